// ----- design/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes for the generational handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

    // Fixed widths of the item fields.
    localparam int CMD_W      = 2;
    localparam int IDX_IN_W   = 8;
    localparam int GEN_IN_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int ANNOUNCE_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_VALIDATE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Announcement codes.
    localparam logic [ANNOUNCE_W-1:0] ANN_NONE      = 2'd0;
    localparam logic [ANNOUNCE_W-1:0] ANN_CREATED   = 2'd1;
    localparam logic [ANNOUNCE_W-1:0] ANN_DESTROYED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_POP,
        S_EXEC
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic rd_stack;
        logic rd_slot_handle;
        logic rd_slot_pop;
        logic exec;
    } t_ctl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic create_pop;
        logic handle_read;
        logic out_free;
    } t_ctl_sts;

endpackage

`default_nettype wire

// ----- design/gha_ctrl.sv -----
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer for one command: operand read, optional stack pop, execute.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire gha_pkg::t_ctl_sts i_sts,
    output gha_pkg::t_ctl_cmd      o_cmd,
    output logic                   o_in_ready
);

    gha_pkg::t_state r_state;
    gha_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gha_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gha_pkg::S_READ;
                end
            end
            gha_pkg::S_READ: begin
                if (i_sts.create_pop) begin
                    n_state = gha_pkg::S_POP;
                end else begin
                    n_state = gha_pkg::S_EXEC;
                end
            end
            gha_pkg::S_POP: begin
                n_state = gha_pkg::S_EXEC;
            end
            gha_pkg::S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = gha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            gha_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            gha_pkg::S_READ: begin
                o_cmd.rd_stack       = i_sts.create_pop;
                o_cmd.rd_slot_handle = i_sts.handle_read;
            end
            gha_pkg::S_POP: begin
                o_cmd.rd_slot_pop = 1'b1;
            end
            gha_pkg::S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/gha_datapath.sv -----
// ----------------------------------------------------------------------------
// gha_datapath
// Free stack, slot memory, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_datapath #(
    parameter int MAX_SLOTS = 256,
    parameter int GEN_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire gha_pkg::t_ctl_cmd                  i_cmd_ctl,
    output gha_pkg::t_ctl_sts                       o_sts,
    input  wire logic [gha_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [gha_pkg::IDX_IN_W-1:0]       i_handle_index,
    input  wire logic [gha_pkg::GEN_IN_W-1:0]       i_handle_generation,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [gha_pkg::STATUS_W-1:0]            o_status,
    output logic [gha_pkg::IDX_IN_W-1:0]            o_out_index,
    output logic [gha_pkg::GEN_IN_W-1:0]            o_out_generation,
    output logic [gha_pkg::ANNOUNCE_W-1:0]          o_announce
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CMP_W  = (CNT_W > gha_pkg::IDX_IN_W) ? CNT_W : gha_pkg::IDX_IN_W;
    localparam int GCMP_W = (GEN_BITS > gha_pkg::GEN_IN_W) ? GEN_BITS : gha_pkg::GEN_IN_W;

    // Latched command.
    logic [gha_pkg::CMD_W-1:0]    r_cmd;
    logic [gha_pkg::IDX_IN_W-1:0] r_hidx;
    logic [gha_pkg::GEN_IN_W-1:0] r_hgen;

    logic [CNT_W-1:0] r_free_cnt;
    logic [CNT_W-1:0] r_used_cnt;
    logic [CNT_W-1:0] n_free_cnt;
    logic [CNT_W-1:0] n_used_cnt;

    // Each slot word holds the alive mark on top of the generation.
    logic [IDX_W-1:0]  r_stack    [MAX_SLOTS];
    logic [GEN_BITS:0] r_slot_mem [MAX_SLOTS];
    logic [IDX_W-1:0]  r_stk_q;
    logic [GEN_BITS:0] r_slot_q;

    logic                            r_out_valid;
    logic [gha_pkg::STATUS_W-1:0]    r_status;
    logic [gha_pkg::IDX_IN_W-1:0]    r_oidx;
    logic [gha_pkg::GEN_IN_W-1:0]    r_ogen;
    logic [gha_pkg::ANNOUNCE_W-1:0]  r_ann;

    logic [CMP_W-1:0]  w_hidx_ext;
    logic [IDX_W-1:0]  w_hidx_addr;
    logic [CNT_W-1:0]  w_top;
    logic              w_in_use;
    logic              w_gen_match;
    logic              w_handle_ok;
    logic              w_is_create;
    logic              w_is_destroy;
    logic              w_is_validate;
    logic              w_room;

    logic [IDX_W-1:0]    w_new_slot;
    logic [GEN_BITS-1:0] w_new_gen;
    logic [CMP_W-1:0]    w_new_slot_x;
    logic [GCMP_W-1:0]   w_new_gen_x;

    logic                 w_slot_we;
    logic [IDX_W-1:0]     w_slot_waddr;
    logic [GEN_BITS:0]    w_slot_wdata;
    logic                 w_stk_we;
    logic [IDX_W-1:0]     w_slot_raddr;

    logic [gha_pkg::STATUS_W-1:0]   n_status;
    logic [gha_pkg::IDX_IN_W-1:0]   n_oidx;
    logic [gha_pkg::GEN_IN_W-1:0]   n_ogen;
    logic [gha_pkg::ANNOUNCE_W-1:0] n_ann;

    assign w_is_create   = (r_cmd == gha_pkg::CMD_CREATE);
    assign w_is_destroy  = (r_cmd == gha_pkg::CMD_DESTROY);
    assign w_is_validate = (r_cmd == gha_pkg::CMD_VALIDATE);

    assign w_hidx_ext  = CMP_W'(r_hidx);
    assign w_hidx_addr = w_hidx_ext[IDX_W-1:0];
    assign w_top       = r_free_cnt - CNT_W'(1);
    assign w_room      = (r_used_cnt < CNT_W'(MAX_SLOTS));

    // Slots at or above the use count were never written; the range check
    // keeps their memory contents out of the decision.
    assign w_in_use    = (w_hidx_ext < CMP_W'(r_used_cnt));
    assign w_gen_match = (GCMP_W'(r_slot_q[GEN_BITS-1:0]) == GCMP_W'(r_hgen));
    assign w_handle_ok = w_in_use && r_slot_q[GEN_BITS] && w_gen_match;

    assign o_sts.create_pop  = w_is_create && (r_free_cnt != '0);
    assign o_sts.handle_read = w_is_destroy || w_is_validate;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    // A fresh slot starts at generation zero.
    assign w_new_slot   = o_sts.create_pop ? r_stk_q : r_used_cnt[IDX_W-1:0];
    assign w_new_gen    = o_sts.create_pop ? r_slot_q[GEN_BITS-1:0] : '0;
    assign w_new_slot_x = CMP_W'(w_new_slot);
    assign w_new_gen_x  = GCMP_W'(w_new_gen);

    assign w_slot_raddr = i_cmd_ctl.rd_slot_pop ? r_stk_q : w_hidx_addr;

    always_comb begin
        n_free_cnt   = r_free_cnt;
        n_used_cnt   = r_used_cnt;
        w_slot_we    = 1'b0;
        w_slot_waddr = w_hidx_addr;
        w_slot_wdata = {1'b0, r_slot_q[GEN_BITS-1:0] + GEN_BITS'(1)};
        w_stk_we     = 1'b0;
        n_status     = gha_pkg::ST_INVALID;
        n_oidx       = '0;
        n_ogen       = '0;
        n_ann        = gha_pkg::ANN_NONE;
        if (w_is_create) begin
            if (o_sts.create_pop || w_room) begin
                w_slot_we    = i_cmd_ctl.exec;
                w_slot_waddr = w_new_slot;
                w_slot_wdata = {1'b1, w_new_gen};
                n_status     = gha_pkg::ST_OK;
                n_oidx       = w_new_slot_x[gha_pkg::IDX_IN_W-1:0];
                n_ogen       = w_new_gen_x[gha_pkg::GEN_IN_W-1:0];
                n_ann        = gha_pkg::ANN_CREATED;
                if (o_sts.create_pop) begin
                    n_free_cnt = w_top;
                end else begin
                    n_used_cnt = r_used_cnt + CNT_W'(1);
                end
            end else begin
                n_status = gha_pkg::ST_FULL;
            end
        end else if (w_is_destroy) begin
            if (w_handle_ok) begin
                w_slot_we  = i_cmd_ctl.exec;
                w_stk_we   = i_cmd_ctl.exec;
                n_free_cnt = r_free_cnt + CNT_W'(1);
                n_status   = gha_pkg::ST_OK;
                n_ann      = gha_pkg::ANN_DESTROYED;
            end
        end else if (w_is_validate) begin
            n_status = w_handle_ok ? gha_pkg::ST_OK : gha_pkg::ST_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            r_cmd  <= i_cmd;
            r_hidx <= i_handle_index;
            r_hgen <= i_handle_generation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack[r_free_cnt[IDX_W-1:0]] <= w_hidx_addr;
        end
        if (i_cmd_ctl.rd_stack) begin
            r_stk_q <= r_stack[w_top[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_waddr] <= w_slot_wdata;
        end
        if (i_cmd_ctl.rd_slot_handle || i_cmd_ctl.rd_slot_pop) begin
            r_slot_q <= r_slot_mem[w_slot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt  <= '0;
            r_used_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd_ctl.exec) begin
                r_free_cnt  <= n_free_cnt;
                r_used_cnt  <= n_used_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.exec) begin
            r_status <= n_status;
            r_oidx   <= n_oidx;
            r_ogen   <= n_ogen;
            r_ann    <= n_ann;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_index      = r_oidx;
    assign o_out_generation = r_ogen;
    assign o_announce       = r_ann;

    // Every freed index was handed out first.
    a_free_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_used_cnt)
        else $error("free count exceeds slots in use");

    a_used_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= CNT_W'(MAX_SLOTS))
        else $error("slots in use exceeds table size");

    a_exec_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ctl.exec |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");

    a_exec_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ctl.exec |=> r_out_valid)
        else $error("executed command produced no result");

    a_pop_needs_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ctl.rd_stack |-> (r_free_cnt != '0))
        else $error("pop from an empty free stack");

endmodule

`default_nettype wire

// ----- design/generational_handle_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Slot map that hands out handles of slot index plus generation count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a command: create,
//   destroy or validate, with a handle for the latter two. Output channel
//   (o_out_valid / i_out_ready) returns exactly one result per command:
//   status, the new handle on a successful create, and an announcement.
//   One command is in flight at a time. After a transfer on the input side
//   the unit reads the operands, then, for a create that pops the free stack,
//   the slot memory at the popped index (stack read, then slot memory read),
//   then executes. The slot and stack memories each give one registered read
//   per cycle; the next command is taken the cycle after the result loads.
//   The result sits in an output register; if the receiver stalls, the unit
//   finishes the next command up to its execute step and waits there.
//   Reset clears the counters and the result valid; the memories need no
//   clearing, since slots at or above the use count are treated as never
//   written (dead, generation zero).
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_unit #(
    parameter int MAX_SLOTS = 256,
    parameter int GEN_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [gha_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [gha_pkg::IDX_IN_W-1:0]       i_handle_index,
    input  wire logic [gha_pkg::GEN_IN_W-1:0]       i_handle_generation,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [gha_pkg::STATUS_W-1:0]            o_status,
    output logic [gha_pkg::IDX_IN_W-1:0]            o_out_index,
    output logic [gha_pkg::GEN_IN_W-1:0]            o_out_generation,
    output logic [gha_pkg::ANNOUNCE_W-1:0]          o_announce
);

    gha_pkg::t_ctl_cmd w_ctl_cmd;
    gha_pkg::t_ctl_sts w_ctl_sts;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_ctl_sts),
        .o_cmd      (w_ctl_cmd),
        .o_in_ready (o_in_ready)
    );

    gha_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .GEN_BITS  (GEN_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_ctl           (w_ctl_cmd),
        .o_sts               (w_ctl_sts),
        .i_cmd               (i_cmd),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_announce          (o_announce)
    );

endmodule

`default_nettype wire

// ----- verif/handle_table_checker.sv -----
// ----------------------------------------------------------------------------
// handle_table_checker
// Watches both channels of the handle allocator and checks every result.
// Keeps its own copy of the slot table and free stack, works out the result
// of each accepted command, and compares it field by field with the result
// that comes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module handle_table_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic [gha_pkg::CMD_W-1:0]               i_cmd,
    input  logic [gha_pkg::IDX_IN_W-1:0]            i_handle_index,
    input  logic [gha_pkg::GEN_IN_W-1:0]            i_handle_generation,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic [gha_pkg::STATUS_W-1:0]            i_status,
    input  logic [gha_pkg::IDX_IN_W-1:0]            i_out_index,
    input  logic [gha_pkg::GEN_IN_W-1:0]            i_out_generation,
    input  logic [gha_pkg::ANNOUNCE_W-1:0]          i_announce,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    localparam int NUM_SLOTS = 256;

    typedef struct packed {
        logic [gha_pkg::STATUS_W-1:0]   status;
        logic [gha_pkg::IDX_IN_W-1:0]   index;
        logic [gha_pkg::GEN_IN_W-1:0]   generation;
        logic [gha_pkg::ANNOUNCE_W-1:0] announce;
    } t_alloc_result;

    logic [7:0]    free_list [NUM_SLOTS];
    logic [8:0]    free_depth;
    logic [8:0]    slots_issued;
    logic [15:0]   slot_gen  [NUM_SLOTS];
    logic          slot_live [NUM_SLOTS];
    t_alloc_result awaited_results [$];

    function automatic logic handle_matches(input logic [7:0] idx, input logic [15:0] gen);
        return ({1'b0, idx} < slots_issued) && slot_live[idx] && (slot_gen[idx] == gen);
    endfunction

    // Applies one command to the local slot table and returns its result.
    function automatic t_alloc_result slot_map_step(input logic [gha_pkg::CMD_W-1:0] cmd,
                                                    input logic [7:0] idx,
                                                    input logic [15:0] gen);
        t_alloc_result res;
        logic [7:0]    slot;
        logic          got;
        res  = '{gha_pkg::ST_INVALID, 8'd0, 16'd0, gha_pkg::ANN_NONE};
        slot = 8'd0;
        got  = 1'b0;
        case (cmd)
            gha_pkg::CMD_CREATE: begin
                if (free_depth != 9'd0) begin
                    free_depth = free_depth - 9'd1;
                    slot       = free_list[free_depth[7:0]];
                    got        = 1'b1;
                end else if (slots_issued < 9'(NUM_SLOTS)) begin
                    slot         = slots_issued[7:0];
                    slots_issued = slots_issued + 9'd1;
                    got          = 1'b1;
                end
                if (got) begin
                    slot_live[slot] = 1'b1;
                    res.status      = gha_pkg::ST_OK;
                    res.index       = slot;
                    res.generation  = slot_gen[slot];
                    res.announce    = gha_pkg::ANN_CREATED;
                end else begin
                    res.status = gha_pkg::ST_FULL;
                end
            end
            gha_pkg::CMD_DESTROY: begin
                if (handle_matches(idx, gen)) begin
                    slot_live[idx] = 1'b0;
                    slot_gen[idx]  = slot_gen[idx] + 16'd1;
                    // A live slot is never on the stack, so there is always room.
                    free_list[free_depth[7:0]] = idx;
                    free_depth   = free_depth + 9'd1;
                    res.status   = gha_pkg::ST_OK;
                    res.announce = gha_pkg::ANN_DESTROYED;
                end
            end
            gha_pkg::CMD_VALIDATE: begin
                res.status = handle_matches(idx, gen) ? gha_pkg::ST_OK : gha_pkg::ST_INVALID;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_alloc_result want;
        t_alloc_result pred;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                free_list[i] = 8'd0;
                slot_gen[i]  = 16'd0;
                slot_live[i] = 1'b0;
            end
            free_depth   = 9'd0;
            slots_issued = 9'd0;
            awaited_results.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                pred = slot_map_step(i_cmd, i_handle_index, i_handle_generation);
                awaited_results.insert(awaited_results.size(), pred);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, i_status);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_status));
                    compare_field("out_index", 32'(want.index), 32'(i_out_index));
                    compare_field("out_generation", 32'(want.generation),
                                  32'(i_out_generation));
                    compare_field("announce", 32'(want.announce), 32'(i_announce));
                end
            end
            o_pending = awaited_results.size();
        end
    end

endmodule

// ----- verif/tb_generational_handle_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator_unit
// Stimulus and verdict for the generational handle allocator.
// Runs directed corner commands, then random phases that mix live, stale and
// random handles while filling the table to full and draining it, with
// random idling on both channels and one long receiver stall. Ends with a
// create/destroy loop that keeps reusing one slot and steps its generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_generational_handle_allocator_unit;

    localparam logic [gha_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 120;
    localparam int WRAP_PAIRS   = 16;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [gha_pkg::CMD_W-1:0]      cmd;
    logic [gha_pkg::IDX_IN_W-1:0]   handle_index;
    logic [gha_pkg::GEN_IN_W-1:0]   handle_generation;
    logic                           out_valid;
    logic                           out_ready;
    logic [gha_pkg::STATUS_W-1:0]   status;
    logic [gha_pkg::IDX_IN_W-1:0]   out_index;
    logic [gha_pkg::GEN_IN_W-1:0]   out_generation;
    logic [gha_pkg::ANNOUNCE_W-1:0] announce;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int created_count = 0;

    bit idle_on       = 1'b1;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    bit track_handles = 1'b0;

    // Handles are packed as {index, generation}.
    logic [23:0] last_created;
    logic [23:0] live_handles  [$];
    logic [23:0] stale_handles [$];

    generational_handle_allocator_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_cmd              (cmd),
        .i_handle_index     (handle_index),
        .i_handle_generation(handle_generation),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_status           (status),
        .o_out_index        (out_index),
        .o_out_generation   (out_generation),
        .o_announce         (announce)
    );

    handle_table_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_cmd              (cmd),
        .i_handle_index     (handle_index),
        .i_handle_generation(handle_generation),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_status           (status),
        .i_out_index        (out_index),
        .i_out_generation   (out_generation),
        .i_announce         (announce),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always #2 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Collects handles from successful creates so later commands can use them.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready && announce == gha_pkg::ANN_CREATED) begin
            last_created  = {out_index, out_generation};
            created_count = created_count + 1;
            if (track_handles)
                live_handles.insert(live_handles.size(), {out_index, out_generation});
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input logic [gha_pkg::CMD_W-1:0] c, input logic [7:0] idx,
                             input logic [15:0] gen);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        cmd               <= c;
        handle_index      <= idx;
        handle_generation <= gen;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // The extra edge lets the checker count the last transfer before we look.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    task automatic send_random(input int create_pct, input int kill_pct);
        int          r;
        int          pos;
        logic [23:0] h;
        logic [gha_pkg::CMD_W-1:0] check_cmd;
        check_cmd = $urandom_range(0, 1) ? gha_pkg::CMD_DESTROY : gha_pkg::CMD_VALIDATE;
        r = $urandom_range(0, 99);
        if (r < create_pct) begin
            send_item(gha_pkg::CMD_CREATE, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < kill_pct + 22 && live_handles.size() > 0) begin
            pos = $urandom_range(0, live_handles.size() - 1);
            h   = live_handles[pos];
            if (r < kill_pct) begin
                live_handles.delete(pos);
                stale_handles.insert(stale_handles.size(), h);
                if (stale_handles.size() > 64)
                    stale_handles.delete(0);
                send_item(gha_pkg::CMD_DESTROY, h[23:16], h[15:0]);
            end else if (r < kill_pct + 15) begin
                send_item(gha_pkg::CMD_VALIDATE, h[23:16], h[15:0]);
            end else begin
                send_item(check_cmd, h[23:16], h[15:0] ^ (16'h1 << $urandom_range(0, 15)));
            end
        end else if (r < kill_pct + 32 && stale_handles.size() > 0) begin
            h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
            send_item(check_cmd, h[23:16], h[15:0]);
        end else if (r < 95) begin
            // Small generations give random handles a real chance to match.
            if (r[0])
                send_item(check_cmd, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            else
                send_item(check_cmd, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 3)));
        end else begin
            send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin : stimulus
        logic [7:0]  wrap_slot;
        logic [15:0] wrap_gen;
        logic [23:0] h;
        int          created_before;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        cmd               <= gha_pkg::CMD_CREATE;
        handle_index      <= 8'd0;
        handle_generation <= 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners on an empty and then tiny table.
        send_item(gha_pkg::CMD_VALIDATE, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_DESTROY, 8'd0, 16'd0);
        send_item(CMD_UNUSED, 8'hFF, 16'hFFFF);
        send_item(gha_pkg::CMD_CREATE, 8'hFF, 16'hFFFF);
        send_item(gha_pkg::CMD_CREATE, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_VALIDATE, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_VALIDATE, 8'd0, 16'd1);
        send_item(gha_pkg::CMD_VALIDATE, 8'd0, 16'h8000);
        send_item(gha_pkg::CMD_DESTROY, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_VALIDATE, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_DESTROY, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_CREATE, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_VALIDATE, 8'd0, 16'd1);
        send_item(gha_pkg::CMD_DESTROY, 8'd1, 16'd0);
        send_item(gha_pkg::CMD_DESTROY, 8'd0, 16'd1);
        send_item(gha_pkg::CMD_CREATE, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_CREATE, 8'd0, 16'd0);
        send_item(gha_pkg::CMD_VALIDATE, 8'd2, 16'd0);
        send_item(gha_pkg::CMD_VALIDATE, 8'hFF, 16'hFFFF);
        send_item(gha_pkg::CMD_DESTROY, 8'hFF, 16'd0);
        send_item(CMD_UNUSED, 8'd0, 16'd0);
        drain_results();
        live_handles.insert(live_handles.size(), {8'd0, 16'd2});
        live_handles.insert(live_handles.size(), {8'd1, 16'd1});
        track_handles = 1'b1;

        repeat (400) send_random(35, 40);
        // Create-heavy: runs the table into full.
        repeat (400) send_random(90, 30);
        // Destroy-heavy: builds a deep free stack.
        repeat (300) send_random(5, 70);
        for (int i = 0; i < 350; i++) begin
            if (i == 150)
                hold_req = 1'b1;
            send_random(40, 40);
        end
        idle_on = 1'b0;
        repeat (100) send_random(40, 40);
        drain_results();

        // Free one slot, take it back, then cycle it a number of times.
        track_handles = 1'b0;
        if (live_handles.size() > 0) begin
            h = live_handles[$];
            live_handles.delete(live_handles.size() - 1);
            send_item(gha_pkg::CMD_DESTROY, h[23:16], h[15:0]);
        end
        created_before = created_count;
        send_item(gha_pkg::CMD_CREATE, 8'd0, 16'd0);
        drain_results();
        if (created_count != created_before) begin
            wrap_slot = last_created[23:16];
            wrap_gen  = last_created[15:0];
            repeat (WRAP_PAIRS) begin
                send_item(gha_pkg::CMD_DESTROY, wrap_slot, wrap_gen);
                send_item(gha_pkg::CMD_CREATE, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
                wrap_gen = wrap_gen + 16'd1;
            end
            send_item(gha_pkg::CMD_VALIDATE, wrap_slot, wrap_gen);
            send_item(gha_pkg::CMD_VALIDATE, wrap_slot, wrap_gen - 16'd1);
            drain_results();
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
